[src/pic_pkg.sv]
package pic_pkg;

    localparam int HDR_MAX_BYTES = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 35;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARKER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAY_OFFSET  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_OFFSET  = 3'd7;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_TRUNCATED = 3'd2,
        ERR_HEADER    = 3'd3,
        ERR_LENGTH    = 3'd4,
        ERR_CHECKSUM  = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [5:0]  mode;
        logic [15:0] min_length;
        logic [34:0] hdr_marker;
        logic [15:0] hdr_offset;
        logic [15:0] len_offset;
        logic [31:0] max_payload;
        logic [15:0] pay_offset;
        logic [15:0] crc_offset;
    } pic_cfg_t;

    // per-packet summary handed from front to back
    typedef struct packed {
        logic        hdr_bad;
        logic [15:0] hdr_bad_pos;
        logic [31:0] length_value;
        logic [31:0] prefix_crc;
        logic [31:0] whole_crc;
        logic [31:0] stored_crc;
    } pkt_sum_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [2:0] marker_len(input logic [34:0] marker);
        logic [2:0] n;
        n = marker[34:32];
        if (n > 3'(HDR_MAX_BYTES)) begin
            n = 3'(HDR_MAX_BYTES);
        end
        return n;
    endfunction

    function automatic logic len_size_ok(input logic [2:0] s);
        return (s == 3'd1) || (s == 3'd2) || (s == 3'd4);
    endfunction

    function automatic logic [15:0] sat16(input logic [32:0] v);
        return (v > 33'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

[src/pic_front.sv]
module pic_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pic_pkg::pic_cfg_t        cfg,
    input  logic                     in_accept,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    output logic                     push_valid,
    output logic [LENGTH_BITS-1:0]   push_count,
    output pic_pkg::pkt_sum_t        push_sum
);
    import pic_pkg::*;

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic [15:0] hdr_pos_reg, hdr_pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] pcrc_reg, pcrc_next;
    logic [31:0] wcrc_reg, wcrc_next;
    logic [31:0] scrc_reg, scrc_next;

    logic [31:0] pos32;
    logic [32:0] hd, ld, cd;
    logic [2:0]  mlen, lsz;
    logic        at_max, in_hdr, in_len, in_crc;
    logic [7:0]  want;

    always_comb begin
        pos32  = 32'(count_reg);
        at_max = &count_reg;
        mlen   = marker_len(cfg.hdr_marker);
        lsz    = cfg.mode[5:3];
        hd     = {1'b0, pos32} - 33'(cfg.hdr_offset);
        ld     = {1'b0, pos32} - 33'(cfg.len_offset);
        cd     = {1'b0, pos32} - 33'(cfg.crc_offset);
        in_hdr = (mlen != 3'd0) && !hd[32] && (hd[31:0] < 32'(mlen));
        in_len = len_size_ok(lsz) && !ld[32] && (ld[31:0] < 32'(lsz));
        in_crc = !cd[32] && (cd[31:0] < 32'd4);
        want   = cfg.hdr_marker[{hd[1:0], 3'b000} +: 8];

        count_next   = count_reg;
        hdr_bad_next = hdr_bad_reg;
        hdr_pos_next = hdr_pos_reg;
        len_next     = len_reg;
        pcrc_next    = pcrc_reg;
        scrc_next    = scrc_reg;
        wcrc_next    = crc32_byte(wcrc_reg, in_byte);
        if (!at_max) begin
            if (in_hdr && (want != in_byte) && !hdr_bad_reg) begin
                hdr_bad_next = 1'b1;
                hdr_pos_next = sat16({1'b0, pos32});
            end
            if (in_len) begin
                len_next = len_reg | (32'(in_byte) << {ld[1:0], 3'b000});
            end
            if (in_crc) begin
                scrc_next = scrc_reg | (32'(in_byte) << {cd[1:0], 3'b000});
            end
            if (cd[32]) begin
                pcrc_next = crc32_byte(pcrc_reg, in_byte);
            end
            count_next = count_reg + LENGTH_BITS'(1);
        end
    end

    assign push_valid              = in_accept && in_last;
    assign push_count              = count_next;
    assign push_sum.hdr_bad        = hdr_bad_next;
    assign push_sum.hdr_bad_pos    = hdr_pos_next;
    assign push_sum.length_value   = len_next;
    assign push_sum.prefix_crc     = ~pcrc_next;
    assign push_sum.whole_crc      = ~wcrc_next;
    assign push_sum.stored_crc     = scrc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || push_valid) begin
            count_reg   <= '0;
            hdr_bad_reg <= 1'b0;
            hdr_pos_reg <= '0;
            len_reg     <= '0;
            pcrc_reg    <= CRC_INIT;
            wcrc_reg    <= CRC_INIT;
            scrc_reg    <= '0;
        end else if (in_accept) begin
            count_reg   <= count_next;
            hdr_bad_reg <= hdr_bad_next;
            hdr_pos_reg <= hdr_pos_next;
            len_reg     <= len_next;
            pcrc_reg    <= pcrc_next;
            wcrc_reg    <= wcrc_next;
            scrc_reg    <= scrc_next;
        end
    end

endmodule

[src/pic_fifo.sv]
module pic_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       level_reg, level_next;

    assign full      = (level_reg == 2'd2);
    assign not_empty = (level_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        level_next = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            level_reg <= level_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !not_empty |-> !pop)
        else $error("pop from empty queue");

    a_ptr_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with level");

endmodule

[src/pic_back.sv]
module pic_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pic_pkg::pic_cfg_t        cfg,
    input  logic                     q_valid,
    input  logic [LENGTH_BITS-1:0]   q_count,
    input  pic_pkg::pkt_sum_t        q_sum,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_ok,
    output pic_pkg::err_code_t       out_code,
    output logic [15:0]              out_offset,
    output logic [31:0]              out_crc
);
    import pic_pkg::*;

    logic        valid_reg;
    logic        ok_reg;
    err_code_t   code_reg, code_next;
    logic [15:0] off_reg, off_next;
    logic [31:0] crc_reg;

    logic [32:0] sz, hdr_end, len_end, exp_len, crc_end;
    logic [2:0]  mlen, lsz;
    logic        len_on, crc_on, strict;

    assign q_pop = q_valid && (!valid_reg || out_ready);

    always_comb begin
        sz      = 33'(q_count);
        mlen    = marker_len(cfg.hdr_marker);
        lsz     = cfg.mode[5:3];
        len_on  = cfg.mode[0];
        strict  = cfg.mode[1];
        crc_on  = cfg.mode[2];
        hdr_end = 33'(cfg.hdr_offset) + 33'(mlen);
        len_end = 33'(cfg.len_offset) + 33'(lsz);
        exp_len = 33'(cfg.pay_offset) + 33'(q_sum.length_value);
        crc_end = 33'(cfg.crc_offset) + 33'd4;

        code_next = ERR_NONE;
        off_next  = 16'd0;
        priority if (sz < 33'(cfg.min_length)) begin
            code_next = ERR_SHORT;     off_next = sat16(sz);
        end else if ((mlen != 3'd0) && (sz < hdr_end)) begin
            code_next = ERR_TRUNCATED; off_next = sat16(sz);
        end else if ((mlen != 3'd0) && q_sum.hdr_bad) begin
            code_next = ERR_HEADER;    off_next = q_sum.hdr_bad_pos;
        end else if (len_on && !len_size_ok(lsz)) begin
            code_next = ERR_LENGTH;    off_next = cfg.len_offset;
        end else if (len_on && (sz < len_end)) begin
            code_next = ERR_TRUNCATED; off_next = sat16(sz);
        end else if (len_on && (cfg.max_payload != 32'd0)
                     && (q_sum.length_value > cfg.max_payload)) begin
            code_next = ERR_LENGTH;    off_next = cfg.len_offset;
        end else if (len_on && (sz < exp_len)) begin
            code_next = ERR_TRUNCATED; off_next = sat16(sz);
        end else if (len_on && strict && (sz != exp_len)) begin
            code_next = ERR_LENGTH;    off_next = sat16(exp_len);
        end else if (crc_on && (crc_end > sz)) begin
            code_next = ERR_TRUNCATED; off_next = sat16(sz);
        end else if (crc_on && (q_sum.stored_crc != q_sum.prefix_crc)) begin
            code_next = ERR_CHECKSUM;  off_next = cfg.crc_offset;
        end else if (crc_on && strict && (sz != crc_end)) begin
            code_next = ERR_LENGTH;    off_next = sat16(crc_end);
        end else begin
            code_next = ERR_NONE;      off_next = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ok_reg   <= (code_next == ERR_NONE);
            code_reg <= code_next;
            off_reg  <= off_next;
            crc_reg  <= q_sum.whole_crc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ok     = ok_reg;
    assign out_code   = code_reg;
    assign out_offset = off_reg;
    assign out_crc    = crc_reg;

endmodule

[src/packet_integrity_checker.sv]
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last_byte
// m_       | out | m_tvalid/m_tready  | m_tdata = packet_ok, fault_code,
//          |     |                    |   error_offset, packet_crc
// cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One byte per cycle while s_tready is high; each request is processed when accepted.
// The verdict is queued at the last byte's accepting edge, then loaded into the
// output register once that register is empty or m_tready is high.
// Per-byte path is two unrolled CRC-32 byte steps plus offset compares.
// s_tready drops only while the two-entry verdict queue is full.
// Reset is synchronous, active low; counts, flags and config clear, CRCs load all ones.
module packet_integrity_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,     // [7:0] data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [55:0]                    m_tdata,     // [0] packet_ok, [3:1] fault_code,
                                                        // [19:4] error_offset,
                                                        // [51:20] packet_crc, [55:52] zero
    input  logic                           cfg_wr_en,
    input  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import pic_pkg::*;

    localparam int Q_WIDTH = LENGTH_BITS + $bits(pkt_sum_t);

    pic_cfg_t cfg_reg;

    logic                   in_accept;
    logic                   push_valid;
    logic [LENGTH_BITS-1:0] push_count, q_count;
    pkt_sum_t               push_sum, q_sum;
    logic                   q_full, q_valid, q_pop;
    logic [Q_WIDTH-1:0]     q_rd_data;
    logic                   out_ok;
    err_code_t              out_code;
    logic [15:0]            out_offset;
    logic [31:0]            out_crc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:        cfg_reg.mode        <= cfg_wr_data[5:0];
                REG_MIN_LENGTH:  cfg_reg.min_length  <= cfg_wr_data[15:0];
                REG_HDR_MARKER:  cfg_reg.hdr_marker  <= cfg_wr_data[34:0];
                REG_HDR_OFFSET:  cfg_reg.hdr_offset  <= cfg_wr_data[15:0];
                REG_LEN_OFFSET:  cfg_reg.len_offset  <= cfg_wr_data[15:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wr_data[31:0];
                REG_PAY_OFFSET:  cfg_reg.pay_offset  <= cfg_wr_data[15:0];
                REG_CRC_OFFSET:  cfg_reg.crc_offset  <= cfg_wr_data[15:0];
            endcase
        end
    end

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    pic_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_count (push_count),
        .push_sum   (push_sum)
    );

    pic_fifo #(.WIDTH(Q_WIDTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data ({push_count, push_sum}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rd_data)
    );

    assign q_count = q_rd_data[Q_WIDTH-1 -: LENGTH_BITS];
    assign q_sum   = q_rd_data[$bits(pkt_sum_t)-1:0];

    pic_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_count    (q_count),
        .q_sum      (q_sum),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ok     (out_ok),
        .out_code   (out_code),
        .out_offset (out_offset),
        .out_crc    (out_crc)
    );

    assign m_tdata = {4'd0, out_crc, out_offset, out_code, out_ok};

    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_ok == (out_code == ERR_NONE)))
        else $error("packet_ok disagrees with fault code");

    a_ok_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_ok) |-> (out_offset == 16'd0))
        else $error("nonzero offset on good packet");

    a_last_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tlast) |=> q_valid)
        else $error("verdict not queued after last byte");

endmodule
